FILE: hdl/bste_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bste_pkg
// Shared types and constants for the BER scalar TLV encoder.
// ----------------------------------------------------------------------------
package bste_pkg;

	// Field widths
	localparam int ACTION_W = 2;
	localparam int TAG_W    = 5;
	localparam int VALUE_W  = 64;
	localparam int BYTE_W   = 8;

	// Longest run: tag, length, pad byte and eight value bytes
	localparam int FRAME_BYTES = 11;
	localparam int IDX_W       = 4;

	// Action codes
	localparam logic [ACTION_W-1:0] ACT_BOOL = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_SINT = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_UINT = 2'd2;

	// Tag number that would mean a long-form tag
	localparam logic [TAG_W-1:0] TAG_LONG_FORM = 5'd31;

	// Byte constants
	localparam logic [BYTE_W-1:0] TAG_CLASS_CONTEXT = 8'h80;
	localparam logic [BYTE_W-1:0] BOOL_TRUE_BYTE    = 8'hFF;
	localparam logic [BYTE_W-1:0] BOOL_FALSE_BYTE   = 8'h00;
	localparam logic [BYTE_W-1:0] ZERO_BYTE         = 8'h00;

	// One encoded run, ready to serialize
	typedef struct packed {
		logic                              keep;     // item produces output
		logic [IDX_W-1:0]                  last_idx; // index of the final byte
		logic [FRAME_BYTES-1:0][BYTE_W-1:0] bytes;
	} frame_t;

endpackage

FILE: hdl/bste_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bste_if
// Valid/ready channels: scalar items in, encoded bytes out.
// ----------------------------------------------------------------------------
interface bste_in_if;
	import bste_pkg::*;
	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [TAG_W-1:0]    tag_number;
	logic [VALUE_W-1:0]  value_bits;

	modport source(output valid, action, tag_number, value_bits, input ready);
	modport sink(input valid, action, tag_number, value_bits, output ready);
endinterface

interface bste_out_if;
	import bste_pkg::*;
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              last;

	modport source(output valid, out_byte, last, input ready);
	modport sink(input valid, out_byte, last, output ready);
endinterface

FILE: hdl/bste_frame_build.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bste_frame_build
// Builds the whole tag-length-value byte run of one item in one pass.
// ----------------------------------------------------------------------------
module bste_frame_build
	import bste_pkg::*;
(
	input  logic [ACTION_W-1:0] action,
	input  logic [TAG_W-1:0]    tag_number,
	input  logic [VALUE_W-1:0]  value_bits,
	output frame_t              frame
);

	localparam int VBYTES = VALUE_W / BYTE_W;

	logic [BYTE_W-1:0]  vb [VBYTES];
	logic [VBYTES-2:0]  red_s;
	logic [VBYTES-2:0]  red_u;
	logic [2:0]         start_s;
	logic [2:0]         start_u;
	logic [2:0]         start;
	logic [VALUE_W-1:0] shifted;
	logic               pad;
	logic [IDX_W-1:0]   clen;
	logic               neg;
	logic [BYTE_W-1:0]  fill;
	logic [BYTE_W-1:0]  bool_byte;
	logic [VALUE_W+BYTE_W-1:0] content;

	// Value split into bytes, most significant first
	always_comb begin
		for (int k = 0; k < VBYTES; k++) begin
			vb[k] = value_bits[BYTE_W*(VBYTES-1-k) +: BYTE_W];
		end
	end

	// Redundant leading bytes for both integer forms
	always_comb begin
		logic run_s;
		logic run_u;
		neg     = value_bits[VALUE_W-1];
		fill    = neg ? BOOL_TRUE_BYTE : ZERO_BYTE;
		run_s   = 1'b1;
		run_u   = 1'b1;
		start_s = '0;
		start_u = '0;
		for (int k = 0; k < VBYTES-1; k++) begin
			red_s[k] = (vb[k] == fill) && (vb[k+1][BYTE_W-1] == neg);
			red_u[k] = (vb[k] == ZERO_BYTE);
			run_s    = run_s & red_s[k];
			run_u    = run_u & red_u[k];
			start_s  = start_s + {2'b00, run_s};
			start_u  = start_u + {2'b00, run_u};
		end
	end

	// Pick the form, align the first kept byte to the top
	always_comb begin
		bool_byte = (value_bits != '0) ? BOOL_TRUE_BYTE : BOOL_FALSE_BYTE;
		start     = (action == ACT_UINT) ? start_u : start_s;
		shifted   = value_bits << {start, 3'b000};
		pad       = 1'b0;
		case (action)
			ACT_BOOL: clen = 4'd1;
			ACT_SINT: clen = 4'd8 - {1'b0, start_s};
			ACT_UINT: begin
				pad  = vb[start_u][BYTE_W-1];
				clen = 4'd8 - {1'b0, start_u} + {3'b000, pad};
			end
			default:  clen = 4'd1;
		endcase
	end

	// Assemble the run; content bytes sit left-aligned in one vector
	always_comb begin
		frame.keep     = (action == ACT_BOOL || action == ACT_SINT || action == ACT_UINT)
			&& (tag_number != TAG_LONG_FORM);
		frame.last_idx = clen + 4'd1;
		frame.bytes[0] = TAG_CLASS_CONTEXT | {3'b000, tag_number};
		frame.bytes[1] = {4'b0000, clen};
		if (action == ACT_BOOL) begin
			content = {bool_byte, {VALUE_W{1'b0}}};
		end else if (pad) begin
			content = {ZERO_BYTE, shifted};
		end else begin
			content = {shifted, ZERO_BYTE};
		end
		for (int p = 0; p < FRAME_BYTES-2; p++) begin
			frame.bytes[p+2] = content[VALUE_W+BYTE_W-1-BYTE_W*p -: BYTE_W];
		end
	end

endmodule

FILE: hdl/ber_scalar_tlv_encoder_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ber_scalar_tlv_encoder_top
// BER context-specific scalar encoder: one item in, a TLV byte run out.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload                              Beat
// din      in   action, tag_number, value_bits       one scalar item
// dout     out  out_byte, last                       one encoded byte
//
// An item waits in the input register, then its whole run is built into the
// frame register and leaves one byte per cycle while dout is ready; a run is
// 3 to 11 bytes. The next item is held and encoded while the current run
// drains. Items with action 3 or tag 31 are dropped without output. Reset clears
// the valid flags and the byte index. A stall on dout holds the current byte.
// ----------------------------------------------------------------------------
module ber_scalar_tlv_encoder_top
	import bste_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	bste_in_if.sink     din,
	bste_out_if.source  dout
);

	logic                valid_s1;
	logic [ACTION_W-1:0] action_s1;
	logic [TAG_W-1:0]    tag_s1;
	logic [VALUE_W-1:0]  value_s1;

	frame_t              frame;
	frame_t              frame_s2;
	logic                valid_s2;
	logic [IDX_W-1:0]    idx_q;

	logic                s2_done;
	logic                s2_free;
	logic                s1_adv;

	// Run builder
	bste_frame_build u_build (
		.action     (action_s1),
		.tag_number (tag_s1),
		.value_bits (value_s1),
		.frame      (frame)
	);

	// Handshake control
	assign s2_done   = valid_s2 && dout.ready && (idx_q == frame_s2.last_idx);
	assign s2_free   = !valid_s2 || s2_done;
	assign s1_adv    = valid_s1 && (s2_free || !frame.keep);
	assign din.ready = !valid_s1 || s1_adv;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (din.valid && din.ready) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (din.valid && din.ready) begin
			action_s1 <= din.action;
			tag_s1    <= din.tag_number;
			value_s1  <= din.value_bits;
		end
	end

	// Frame register and byte index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= '0;
		end else if (s1_adv && frame.keep) begin
			valid_s2 <= 1'b1;
			idx_q    <= '0;
		end else if (s2_done) begin
			valid_s2 <= 1'b0;
		end else if (valid_s2 && dout.ready) begin
			idx_q <= idx_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && frame.keep) begin
			frame_s2 <= frame;
		end
	end

	// Output beat
	assign dout.valid    = valid_s2;
	assign dout.out_byte = frame_s2.bytes[idx_q];
	assign dout.last     = (idx_q == frame_s2.last_idx);

endmodule
